/* src/alpha_unpremultiply_pixel_core_assert.svh */
// Assertion macros used by the pixel core control module.
`ifndef ALPHA_UNPREMULTIPLY_PIXEL_CORE_ASSERT_SVH
`define ALPHA_UNPREMULTIPLY_PIXEL_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define AUP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Checks that a condition never holds outside reset.
`define AUP_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: label");

`else

`define AUP_ASSERT(label, prop)
`define AUP_ASSERT_NEVER(label, cond)

`endif

`endif

/* src/aup_pkg.sv */
// Types, constants and the reciprocal table of the alpha un-premultiply core.
package aup_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_W       = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int ALPHA_CODES = 1 << CHAN_W;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha_in;
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic              row_end_in;
        logic              frame_end_in;
    } pix_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
        logic              row_end_out;
        logic              frame_end_out;
    } pix_out_t;

    // Load enables of the three pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    typedef logic [ALPHA_CODES-1:0][RECIP_W-1:0] recip_tab_t;

    // Entry d holds floor(2^24 / d), built by restoring long division at
    // elaboration. Entry zero is unused.
    function automatic recip_tab_t build_recip_tab();
        recip_tab_t         tab;
        logic [RECIP_W-1:0] quo;
        logic [CHAN_W:0]    rem;
        tab = '0;
        for (int d = 1; d < ALPHA_CODES; d++)
        begin
            rem = '0;
            quo = '0;
            for (int b = RECIP_SHIFT; b >= 0; b--)
            begin
                rem = {rem[CHAN_W-1:0], (b == RECIP_SHIFT)};
                if (rem >= (CHAN_W+1)'(d))
                begin
                    rem    = rem - (CHAN_W+1)'(d);
                    quo[b] = 1'b1;
                end
            end
            tab[d] = quo;
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip_tab();

endpackage

/* src/aup_channel.sv */
// Three-stage rounded division of one color channel by alpha.
module aup_channel
    import aup_pkg::*;
(
    input  logic                clk,
    input  stage_en_t           en,
    input  logic [CHAN_W-1:0]   chan,
    input  logic [CHAN_W-1:0]   alpha,
    input  logic [RECIP_W-1:0]  recip_s1,
    input  logic [CHAN_W-1:0]   alpha_s2,
    output logic [CHAN_W-1:0]   result
);

    logic [NUM_W-1:0]          num_s1_reg, num_s1_next;
    logic                      sat_s1_reg, sat_s1_next;
    logic [NUM_W-1:0]          num_s2_reg;
    logic                      sat_s2_reg;
    logic [CHAN_W-1:0]         quo_s2_reg, quo_s2_next;
    logic [CHAN_W-1:0]         result_reg, result_next;
    logic [NUM_W+RECIP_W-1:0]  prod;
    logic [NUM_W-1:0]          back;
    logic [NUM_W-1:0]          rem;
    logic [CHAN_W-1:0]         quo_fixed;

    // Numerator c*255 + alpha/2. A color at or above a nonzero alpha ends at
    // full scale, which keeps the quotient to eight bits otherwise.
    always_comb
    begin
        num_s1_next = {chan, {CHAN_W{1'b0}}} - NUM_W'(chan) + NUM_W'(alpha[CHAN_W-1:1]);
        sat_s1_next = (chan >= alpha);
    end

    // The reciprocal estimate is exact or one below the true quotient.
    assign prod        = (NUM_W+RECIP_W)'(num_s1_reg) * (NUM_W+RECIP_W)'(recip_s1);
    assign quo_s2_next = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];

    always_comb
    begin
        back      = NUM_W'(quo_s2_reg) * NUM_W'(alpha_s2);
        rem       = num_s2_reg - back;
        quo_fixed = quo_s2_reg + CHAN_W'(rem >= NUM_W'(alpha_s2));
        if (alpha_s2 == '0)
            result_next = '0;
        else if (sat_s2_reg)
            result_next = FULL_SCALE;
        else
            result_next = quo_fixed;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            num_s1_reg <= num_s1_next;
            sat_s1_reg <= sat_s1_next;
        end
        if (en.s2)
        begin
            num_s2_reg <= num_s1_reg;
            sat_s2_reg <= sat_s1_reg;
            quo_s2_reg <= quo_s2_next;
        end
        if (en.s3)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

/* src/aup_ctrl.sv */
// Valid and ready chain of the three-stage pixel pipeline.
module aup_ctrl
    import aup_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output stage_en_t en
);

`include "alpha_unpremultiply_pixel_core_assert.svh"

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic ready1, ready2, ready3;

    // A stage takes a new request when it is empty or its content moves on.
    always_comb
    begin
        ready3  = !v3_reg || out_ready;
        ready2  = !v2_reg || ready3;
        ready1  = !v1_reg || ready2;
        en.s1   = in_valid && ready1;
        en.s2   = v1_reg && ready2;
        en.s3   = v2_reg && ready3;
        v1_next = ready1 ? in_valid : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
        v3_next = ready3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign in_ready  = ready1;
    assign out_valid = v3_reg;

    `AUP_ASSERT(a_bubble_gives_ready, (!v1_reg || !v2_reg || !v3_reg) |-> in_ready)
    `AUP_ASSERT(a_accept_fills_s1, en.s1 |=> v1_reg)
    `AUP_ASSERT(a_s1_holds_on_stall, (v1_reg && !ready2) |=> (v1_reg && $stable(v2_reg)))
    `AUP_ASSERT(a_s3_load_shows, en.s3 |=> out_valid)
    `AUP_ASSERT_NEVER(a_load_without_data, en.s3 && !v2_reg)

endmodule

/* src/alpha_unpremultiply_pixel_core.sv */
// Alpha un-premultiply core: premultiplied ARGB in, straight color out,
// one pixel per clock. Each color becomes round(c * 255 / alpha), forced to
// zero when alpha is zero and to 255 when the color is at or above alpha;
// alpha and the row and frame end marks pass through with the pixel. Every
// pixel passes through three register stages (numerator and reciprocal
// lookup, reciprocal multiply, back-multiply correction). A new request is
// taken every cycle while the output side accepts; when it stalls the
// pipeline holds up to three pixels before in_ready drops.
module alpha_unpremultiply_pixel_core
    import aup_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_out_t out_data
);

    stage_en_t          en;
    logic [RECIP_W-1:0] recip_s1_reg;
    logic [CHAN_W-1:0]  alpha_s1_reg, alpha_s2_reg, alpha_s3_reg;
    logic [1:0]         marks_s1_reg, marks_s2_reg, marks_s3_reg;
    logic [CHAN_W-1:0]  red_res, green_res, blue_res;

    aup_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            recip_s1_reg <= RECIP_TAB[in_data.alpha_in];
            alpha_s1_reg <= in_data.alpha_in;
            marks_s1_reg <= {in_data.row_end_in, in_data.frame_end_in};
        end
        if (en.s2)
        begin
            alpha_s2_reg <= alpha_s1_reg;
            marks_s2_reg <= marks_s1_reg;
        end
        if (en.s3)
        begin
            alpha_s3_reg <= alpha_s2_reg;
            marks_s3_reg <= marks_s2_reg;
        end
    end

    aup_channel u_red (
        .clk      (clk),
        .en       (en),
        .chan     (in_data.red_in),
        .alpha    (in_data.alpha_in),
        .recip_s1 (recip_s1_reg),
        .alpha_s2 (alpha_s2_reg),
        .result   (red_res)
    );

    aup_channel u_green (
        .clk      (clk),
        .en       (en),
        .chan     (in_data.green_in),
        .alpha    (in_data.alpha_in),
        .recip_s1 (recip_s1_reg),
        .alpha_s2 (alpha_s2_reg),
        .result   (green_res)
    );

    aup_channel u_blue (
        .clk      (clk),
        .en       (en),
        .chan     (in_data.blue_in),
        .alpha    (in_data.alpha_in),
        .recip_s1 (recip_s1_reg),
        .alpha_s2 (alpha_s2_reg),
        .result   (blue_res)
    );

    always_comb
    begin
        out_data.red_out       = red_res;
        out_data.green_out     = green_res;
        out_data.blue_out      = blue_res;
        out_data.alpha_out     = alpha_s3_reg;
        out_data.row_end_out   = marks_s3_reg[1];
        out_data.frame_end_out = marks_s3_reg[0];
    end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the alpha un-premultiply pixel core.
`timescale 1ns / 100ps

module testbench;
    import aup_pkg::*;

    localparam int DRAIN_CYCLES = 12;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    pix_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    pix_out_t out_data;

    pix_in_t  pixels_to_send[$];
    pix_out_t expected_pixels[$];

    int send_wait = 0;
    int recv_wait = 0;
    int send_style = 0;
    int recv_style = 0;
    int pixels_sent = 0;
    int pixels_checked = 0;
    int error_count = 0;
    int zero_alpha_count = 0;
    int overrange_count = 0;

    alpha_unpremultiply_pixel_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Rounded division by alpha, clamped at full scale; zero when alpha is zero.
    function automatic logic [CHAN_W-1:0] straight_channel(logic [CHAN_W-1:0] c,
                                                           logic [CHAN_W-1:0] a);
        int unsigned q;
        if (a == '0)
            return '0;
        q = (int'(c) * 255 + (int'(a) >> 1)) / int'(a);
        if (q > 255)
            q = 255;
        return q[CHAN_W-1:0];
    endfunction

    function automatic pix_out_t unpremultiply_pixel(pix_in_t px);
        pix_out_t r;
        r.red_out       = straight_channel(px.red_in, px.alpha_in);
        r.green_out     = straight_channel(px.green_in, px.alpha_in);
        r.blue_out      = straight_channel(px.blue_in, px.alpha_in);
        r.alpha_out     = px.alpha_in;
        r.row_end_out   = px.row_end_in;
        r.frame_end_out = px.frame_end_in;
        return r;
    endfunction

    // Style 0 never idles, style 1 idles now and then, style 2 idles often.
    function automatic int draw_wait(int style);
        if (style == 0)
            return 0;
        if (style == 1)
            return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic pix_in_t make_pixel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] r,
                                           logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b,
                                           logic row_end, logic frame_end);
        pix_in_t px;
        px.alpha_in     = a;
        px.red_in       = r;
        px.green_in     = g;
        px.blue_in      = b;
        px.row_end_in   = row_end;
        px.frame_end_in = frame_end;
        return px;
    endfunction

    function automatic logic [CHAN_W-1:0] random_alpha();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly valid premultiplied colors (not above alpha), sometimes anything.
    function automatic logic [CHAN_W-1:0] random_color(logic [CHAN_W-1:0] a);
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: return '0;
            1: return a;
            default: return 8'($urandom_range(0, int'(a)));
        endcase
    endfunction

    task automatic queue_pixel(pix_in_t px);
        if (px.alpha_in == '0)
            zero_alpha_count++;
        else if (px.red_in > px.alpha_in || px.green_in > px.alpha_in
                 || px.blue_in > px.alpha_in)
            overrange_count++;
        pixels_to_send.push_back(px);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Request driver: holds each request until taken, then waits its drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(unpremultiply_pixel(in_data));
                pixels_sent++;
                if ($urandom_range(0, 39) == 0)
                    send_style = $urandom_range(0, 2);
                send_wait = draw_wait(send_style);
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait == 0 && pixels_to_send.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pixels_to_send.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (send_wait > 0)
                        send_wait--;
                end
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %h", $time, out_data);
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", 32'(want.red_out), 32'(out_data.red_out));
                    check_field("green", 32'(want.green_out), 32'(out_data.green_out));
                    check_field("blue", 32'(want.blue_out), 32'(out_data.blue_out));
                    check_field("alpha", 32'(want.alpha_out), 32'(out_data.alpha_out));
                    check_field("row_end", 32'(want.row_end_out),
                                32'(out_data.row_end_out));
                    check_field("frame_end", 32'(want.frame_end_out),
                                32'(out_data.frame_end_out));
                    pixels_checked++;
                end
                if ($urandom_range(0, 39) == 0)
                    recv_style = $urandom_range(0, 2);
                recv_wait = draw_wait(recv_style);
            end
            if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [CHAN_W-1:0] a;
        logic              row_end;

        // Zero alpha, including colors that would otherwise saturate.
        queue_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
        // Opaque pixels pass the color through.
        queue_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0));
        queue_pixel(make_pixel(8'd255, 8'd128, 8'd1, 8'd254, 1'b0, 1'b1));
        // Smallest alphas and the rounding of half steps.
        queue_pixel(make_pixel(8'd1, 8'd0, 8'd1, 8'd255, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd2, 8'd1, 8'd2, 8'd0, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd3, 8'd1, 8'd2, 8'd3, 1'b1, 1'b0));
        queue_pixel(make_pixel(8'd128, 8'd64, 8'd127, 8'd1, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd254, 8'd253, 8'd127, 8'd1, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd7, 8'd3, 8'd4, 8'd6, 1'b0, 1'b0));
        // Color equal to alpha and color above alpha.
        queue_pixel(make_pixel(8'd100, 8'd100, 8'd101, 8'd99, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd10, 8'd200, 8'd255, 8'd11, 1'b1, 1'b0));
        queue_pixel(make_pixel(8'd1, 8'd2, 8'd128, 8'd255, 1'b0, 1'b0));
        queue_pixel(make_pixel(8'd170, 8'd85, 8'd170, 8'd171, 1'b1, 1'b1));

        for (int i = 0; i < 800; i++)
        begin
            a = random_alpha();
            row_end = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) == 0)
                queue_pixel(make_pixel(a, random_color(a), random_color(a), random_color(a),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            else
                queue_pixel(make_pixel(a, random_color(a), random_color(a), random_color(a),
                                       row_end, row_end && ($urandom_range(0, 3) == 0)));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pixels_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d pixels and checked %0d results.", pixels_sent, pixels_checked);
        $display("Zero-alpha pixels: %0d, pixels with a color above alpha: %0d.",
                 zero_alpha_count, overrange_count);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Timeout with %0d results outstanding.", expected_pixels.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
